@@ hw/rtl/bllm_pkg.sv @@
`default_nettype none

package bllm_pkg;

   localparam int CAPACITY = 64;
   localparam int IDX_W    = $clog2(CAPACITY);
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int VAL_W    = 32;

   // request codes
   localparam logic [2:0] RQ_INS_HEAD = 3'd0;
   localparam logic [2:0] RQ_INS_TAIL = 3'd1;
   localparam logic [2:0] RQ_DEL_HEAD = 3'd2;
   localparam logic [2:0] RQ_DEL_VAL  = 3'd3;
   localparam logic [2:0] RQ_CLEAR    = 3'd4;
   localparam logic [2:0] RQ_DUMP     = 3'd5;

   // result status codes
   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_FULL  = 2'd1;
   localparam logic [1:0] ST_EMPTY = 2'd2;

   // datapath operations
   localparam logic [3:0] OP_NONE       = 4'd0;
   localparam logic [3:0] OP_START_INS  = 4'd1;
   localparam logic [3:0] OP_START_LIST = 4'd2;
   localparam logic [3:0] OP_CLEAR      = 4'd3;
   localparam logic [3:0] OP_INS_HEAD   = 4'd4;
   localparam logic [3:0] OP_INS_TAIL   = 4'd5;
   localparam logic [3:0] OP_DEL_HEAD   = 4'd6;
   localparam logic [3:0] OP_WALK_HIT   = 4'd7;
   localparam logic [3:0] OP_STEP       = 4'd8;
   localparam logic [3:0] OP_RELEASE    = 4'd9;

   // result value source
   localparam logic [1:0] SRC_ZERO = 2'd0;
   localparam logic [1:0] SRC_MEM  = 2'd1;
   localparam logic [1:0] SRC_REQ  = 2'd2;

   typedef struct packed {
      logic [3:0] op;
      logic       emit;
      logic [1:0] emit_status;
      logic [1:0] emit_src;
      logic       emit_last;
   } cmd_type;

   typedef struct packed {
      logic count_zero;
      logic pool_full;
      logic hit;
      logic at_last;
      logic out_free;
   } stat_type;

   // free list link of a node after reset or clear
   function automatic logic [IDX_W-1:0] link_reset(input logic [IDX_W-1:0] idx);
      logic [IDX_W-1:0] res;
      if (idx == IDX_W'(CAPACITY - 1)) begin
         res = '0;
      end else begin
         res = idx + IDX_W'(1);
      end
      return res;
   endfunction

endpackage

`default_nettype wire

@@ hw/rtl/bounded_linked_list_manager_core.sv @@
// Bounded singly linked list of signed 32-bit values in a pool of 64 nodes.
// Request channel (req_*): req_type selects insert head, insert tail, delete
// head, delete value, clear or dump; req_item_value is the value to insert or
// to find. One request is taken at a time; req_ready is high while idle.
// Response channel (rsp_*): each word carries status, out_value, last and the
// list count after the request. Dump gives one word per node, last set on the
// final one, or one empty word for an empty list; every other request gives
// exactly one word. Insert, delete head, clear, unused codes and the refused
// or empty answers go from the accept straight to an emit state; delete value
// first walks the list, and dump loads one word per node. Delete value and
// dump walk the links one node per cycle (a dump only while the output word
// can move), set by the registered read port of the node memories.
// A response register sits on the output; when rsp_ready is low the word waits
// there, and a dump holds on its current node until the word is taken.
// The next request can be taken in the cycle after the last word of the
// current one is loaded; requests never overlap.
// Reset (synchronous) empties the list and returns all nodes to the free list.
`default_nettype none

module bounded_linked_list_manager_core (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_ready,
   input  wire logic [2:0]                          req_type,
   input  wire logic signed [bllm_pkg::VAL_W-1:0]   req_item_value,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output logic [1:0]                               rsp_status,
   output logic signed [bllm_pkg::VAL_W-1:0]        rsp_out_value,
   output logic                                     rsp_last,
   output logic [bllm_pkg::CNT_W-1:0]               rsp_list_count
);
   import bllm_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   bllm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_type  (req_type),
      .stat      (stat),
      .cmd       (cmd)
   );

   bllm_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .req_item_value (req_item_value),
      .cmd            (cmd),
      .stat           (stat),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_status     (rsp_status),
      .rsp_out_value  (rsp_out_value),
      .rsp_last       (rsp_last),
      .rsp_list_count (rsp_list_count)
   );

endmodule

`default_nettype wire

@@ hw/rtl/bllm_ctrl.sv @@
`default_nettype none

module bllm_ctrl (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic [2:0]         req_type,
   input  wire bllm_pkg::stat_type stat,
   output bllm_pkg::cmd_type       cmd
);
   import bllm_pkg::*;

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_EMIT = 3'd1;
   localparam logic [2:0] S_INS  = 3'd2;
   localparam logic [2:0] S_DELH = 3'd3;
   localparam logic [2:0] S_WALK = 3'd4;
   localparam logic [2:0] S_REL  = 3'd5;
   localparam logic [2:0] S_DUMP = 3'd6;

   logic [2:0] state_ff, state_in;
   logic [1:0] pend_ff, pend_in;
   logic       tail_ff, tail_in;

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in        = state_ff;
      pend_in         = pend_ff;
      tail_in         = tail_ff;
      cmd.op          = OP_NONE;
      cmd.emit        = 1'b0;
      cmd.emit_status = ST_OK;
      cmd.emit_src    = SRC_ZERO;
      cmd.emit_last   = 1'b1;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               case (req_type)
                  RQ_INS_HEAD, RQ_INS_TAIL: begin
                     cmd.op  = OP_START_INS;
                     tail_in = (req_type == RQ_INS_TAIL);
                     if (stat.pool_full) begin
                        pend_in  = ST_FULL;
                        state_in = S_EMIT;
                     end else begin
                        state_in = S_INS;
                     end
                  end
                  RQ_DEL_HEAD, RQ_DEL_VAL, RQ_DUMP: begin
                     cmd.op = OP_START_LIST;
                     if (stat.count_zero) begin
                        pend_in  = ST_EMPTY;
                        state_in = S_EMIT;
                     end else if (req_type == RQ_DEL_HEAD) begin
                        state_in = S_DELH;
                     end else if (req_type == RQ_DEL_VAL) begin
                        state_in = S_WALK;
                     end else begin
                        state_in = S_DUMP;
                     end
                  end
                  RQ_CLEAR: begin
                     cmd.op   = OP_CLEAR;
                     pend_in  = ST_OK;
                     state_in = S_EMIT;
                  end
                  default: begin
                     pend_in  = ST_OK;
                     state_in = S_EMIT;
                  end
               endcase
            end
         end
         S_EMIT: begin
            if (stat.out_free) begin
               cmd.emit        = 1'b1;
               cmd.emit_status = pend_ff;
               state_in        = S_IDLE;
            end
         end
         S_INS: begin
            if (stat.out_free) begin
               cmd.op   = tail_ff ? OP_INS_TAIL : OP_INS_HEAD;
               cmd.emit = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_DELH: begin
            if (stat.out_free) begin
               cmd.op       = OP_DEL_HEAD;
               cmd.emit     = 1'b1;
               cmd.emit_src = SRC_MEM;
               state_in     = S_IDLE;
            end
         end
         S_WALK: begin
            if (stat.hit) begin
               cmd.op   = OP_WALK_HIT;
               state_in = S_REL;
            end else if (stat.at_last) begin
               pend_in  = ST_EMPTY;
               state_in = S_EMIT;
            end else begin
               cmd.op = OP_STEP;
            end
         end
         S_REL: begin
            if (stat.out_free) begin
               cmd.op       = OP_RELEASE;
               cmd.emit     = 1'b1;
               cmd.emit_src = SRC_REQ;
               state_in     = S_IDLE;
            end
         end
         S_DUMP: begin
            if (stat.out_free) begin
               cmd.emit      = 1'b1;
               cmd.emit_src  = SRC_MEM;
               cmd.emit_last = stat.at_last;
               if (stat.at_last) begin
                  state_in = S_IDLE;
               end else begin
                  cmd.op = OP_STEP;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
      pend_ff <= pend_in;
      tail_ff <= tail_in;
   end

endmodule

`default_nettype wire

@@ hw/rtl/bllm_datapath.sv @@
`default_nettype none

module bllm_datapath (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic signed [bllm_pkg::VAL_W-1:0]   req_item_value,
   input  wire bllm_pkg::cmd_type                   cmd,
   output bllm_pkg::stat_type                       stat,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output logic [1:0]                               rsp_status,
   output logic signed [bllm_pkg::VAL_W-1:0]        rsp_out_value,
   output logic                                     rsp_last,
   output logic [bllm_pkg::CNT_W-1:0]               rsp_list_count
);
   import bllm_pkg::*;

   logic signed [VAL_W-1:0] values_mem [CAPACITY];
   logic [IDX_W-1:0]        links_mem  [CAPACITY];

   logic [CAPACITY-1:0]     lvalid_ff, lvalid_in;
   logic [IDX_W-1:0]        head_ff, head_in;
   logic [IDX_W-1:0]        tail_ff, tail_in;
   logic [IDX_W-1:0]        free_ff, free_in;
   logic [CNT_W-1:0]        count_ff, count_in;
   logic [IDX_W-1:0]        cur_ff, cur_in;
   logic [IDX_W-1:0]        prev_ff, prev_in;
   logic [IDX_W-1:0]        idx_ff, idx_in;
   logic signed [VAL_W-1:0] val_ff, val_in;

   logic signed [VAL_W-1:0] value_rd_ff;
   logic [IDX_W-1:0]        link_mem_rd_ff;
   logic                    lvalid_rd_ff;
   logic [IDX_W-1:0]        link_rd;

   logic                    value_we;
   logic                    link_we;
   logic [IDX_W-1:0]        link_waddr;
   logic [IDX_W-1:0]        link_wdata;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic [1:0]              rsp_status_ff;
   logic signed [VAL_W-1:0] rsp_value_ff, rsp_value_in;
   logic                    rsp_last_ff;
   logic [CNT_W-1:0]        rsp_count_ff;

   assign link_rd = lvalid_rd_ff ? link_mem_rd_ff : link_reset(cur_ff);

   assign stat.count_zero = (count_ff == '0);
   assign stat.pool_full  = (count_ff >= CNT_W'(CAPACITY));
   assign stat.hit        = (value_rd_ff == val_ff);
   assign stat.at_last    = ((CNT_W'(idx_ff) + CNT_W'(1)) == count_ff);
   assign stat.out_free   = !rsp_valid_ff || rsp_ready;

   always_comb begin
      lvalid_in  = lvalid_ff;
      head_in    = head_ff;
      tail_in    = tail_ff;
      free_in    = free_ff;
      count_in   = count_ff;
      cur_in     = cur_ff;
      prev_in    = prev_ff;
      idx_in     = idx_ff;
      val_in     = val_ff;
      value_we   = 1'b0;
      link_we    = 1'b0;
      link_waddr = cur_ff;
      link_wdata = free_ff;
      case (cmd.op)
         OP_START_INS: begin
            cur_in = free_ff;
            val_in = req_item_value;
         end
         OP_START_LIST: begin
            cur_in  = head_ff;
            prev_in = '0;
            idx_in  = '0;
            val_in  = req_item_value;
         end
         OP_CLEAR: begin
            lvalid_in = '0;
            head_in   = '0;
            tail_in   = '0;
            free_in   = '0;
            count_in  = '0;
         end
         OP_INS_HEAD, OP_INS_TAIL: begin
            free_in  = link_rd;
            value_we = 1'b1;
            count_in = count_ff + CNT_W'(1);
            if (count_ff == '0) begin
               head_in = cur_ff;
               tail_in = cur_ff;
            end else if (cmd.op == OP_INS_HEAD) begin
               link_we    = 1'b1;
               link_waddr = cur_ff;
               link_wdata = head_ff;
               head_in    = cur_ff;
            end else begin
               link_we    = 1'b1;
               link_waddr = tail_ff;
               link_wdata = cur_ff;
               tail_in    = cur_ff;
            end
         end
         OP_DEL_HEAD: begin
            head_in  = link_rd;
            link_we  = 1'b1;
            free_in  = cur_ff;
            count_in = count_ff - CNT_W'(1);
         end
         OP_WALK_HIT: begin
            if (idx_ff == '0) begin
               head_in = link_rd;
            end else begin
               link_we    = 1'b1;
               link_waddr = prev_ff;
               link_wdata = link_rd;
            end
            if (stat.at_last) begin
               tail_in = prev_ff;
            end
         end
         OP_STEP: begin
            prev_in = cur_ff;
            cur_in  = link_rd;
            idx_in  = idx_ff + IDX_W'(1);
         end
         OP_RELEASE: begin
            link_we  = 1'b1;
            free_in  = cur_ff;
            count_in = count_ff - CNT_W'(1);
         end
         default: begin
         end
      endcase
      if (link_we) begin
         lvalid_in[link_waddr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      value_rd_ff    <= values_mem[cur_in];
      link_mem_rd_ff <= links_mem[cur_in];
      lvalid_rd_ff   <= lvalid_ff[cur_in];
      if (value_we) begin
         values_mem[cur_ff] <= val_ff;
      end
      if (link_we) begin
         links_mem[link_waddr] <= link_wdata;
      end
   end

   always_comb begin
      case (cmd.emit_src)
         SRC_MEM: rsp_value_in = value_rd_ff;
         SRC_REQ: rsp_value_in = val_ff;
         default: rsp_value_in = '0;
      endcase
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lvalid_ff    <= '0;
         head_ff      <= '0;
         tail_ff      <= '0;
         free_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         lvalid_ff    <= lvalid_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         free_ff      <= free_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cur_ff  <= cur_in;
      prev_ff <= prev_in;
      idx_ff  <= idx_in;
      val_ff  <= val_in;
      if (cmd.emit) begin
         rsp_status_ff <= cmd.emit_status;
         rsp_value_ff  <= rsp_value_in;
         rsp_last_ff   <= cmd.emit_last;
         rsp_count_ff  <= count_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_out_value  = rsp_value_ff;
   assign rsp_last       = rsp_last_ff;
   assign rsp_list_count = rsp_count_ff;

endmodule

`default_nettype wire

@@ sim/tb.sv @@
`default_nettype none

module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import bllm_pkg::*;

   localparam logic [2:0] RQ_SPARE_A = 3'd6;
   localparam logic [2:0] RQ_SPARE_B = 3'd7;

   localparam int STALL_LIMIT  = 3000;
   localparam int HOLD_AT      = 30;
   localparam int HOLD_CYCLES  = 300;
   localparam int DRAIN_CYCLES = 100;

   typedef struct {
      logic [2:0]  kind;
      logic [31:0] value;
   } list_req_type;

   typedef struct packed {
      logic [1:0]       status;
      logic [31:0]      value;
      logic             last;
      logic [CNT_W-1:0] count;
   } list_word_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                     req_valid = 1'b0;
   logic                     req_ready;
   logic [2:0]               req_type = '0;
   logic signed [VAL_W-1:0]  req_item_value = '0;
   logic                     rsp_valid;
   logic                     rsp_ready = 1'b0;
   logic [1:0]               rsp_status;
   logic signed [VAL_W-1:0]  rsp_out_value;
   logic                     rsp_last;
   logic [CNT_W-1:0]         rsp_list_count;

   list_req_type  req_backlog[$];
   list_word_type words_due[$];
   logic [31:0]   shadow_list[$];

   int          items_total = 0;
   int          req_issued = 0;
   int          req_accepted = 0;
   int unsigned req_gap = 0;
   bit          req_burst = 1'b0;
   int          rsp_words = 0;
   int          rsp_seen = 0;
   int unsigned rsp_wait = 0;
   bit          rsp_burst = 1'b0;
   bit          hold_done = 1'b0;
   int          stall_cycles = 0;
   int          bad_words = 0;

   bounded_linked_list_manager_core dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_type       (req_type),
      .req_item_value (req_item_value),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_status     (rsp_status),
      .rsp_out_value  (rsp_out_value),
      .rsp_last       (rsp_last),
      .rsp_list_count (rsp_list_count)
   );

   always #6 clock = ~clock;

   function automatic void add_req(logic [2:0] kind, logic [31:0] value);
      list_req_type r;
      r.kind  = kind;
      r.value = value;
      req_backlog.push_back(r);
   endfunction

   // half fully random, half from a small set so deletes by value hit
   function automatic logic [31:0] pick_value();
      logic [31:0] v;
      if ($urandom_range(0, 1) == 1) begin
         v = $urandom;
      end else begin
         case ($urandom_range(0, 5))
            0: v = 32'h0000_0000;
            1: v = 32'hffff_ffff;
            2: v = 32'h0000_0001;
            3: v = 32'h7fff_ffff;
            4: v = 32'h8000_0000;
            default: v = 32'h1234_5678;
         endcase
      end
      return v;
   endfunction

   function automatic void add_mixed();
      int unsigned r;
      logic [2:0]  kind;
      r = $urandom_range(0, 99);
      if (r < 22) begin
         kind = RQ_INS_HEAD;
      end else if (r < 44) begin
         kind = RQ_INS_TAIL;
      end else if (r < 56) begin
         kind = RQ_DEL_HEAD;
      end else if (r < 78) begin
         kind = RQ_DEL_VAL;
      end else if (r < 90) begin
         kind = RQ_DUMP;
      end else if (r < 94) begin
         kind = RQ_CLEAR;
      end else if (r < 97) begin
         kind = RQ_SPARE_A;
      end else begin
         kind = RQ_SPARE_B;
      end
      add_req(kind, pick_value());
   endfunction

   function automatic void expect_word(logic [1:0] status, logic [31:0] value, logic last);
      list_word_type w;
      w.status = status;
      w.value  = value;
      w.last   = last;
      w.count  = CNT_W'(shadow_list.size());
      words_due.push_back(w);
   endfunction

   // list contents kept as an ordered queue; count is taken after the change
   function automatic void list_apply(logic [2:0] kind, logic [31:0] value);
      int          hit;
      logic [31:0] head;
      hit = -1;
      case (kind)
         RQ_INS_HEAD, RQ_INS_TAIL: begin
            if (shadow_list.size() >= CAPACITY) begin
               expect_word(ST_FULL, '0, 1'b1);
            end else begin
               if (kind == RQ_INS_HEAD) begin
                  shadow_list.push_front(value);
               end else begin
                  shadow_list.push_back(value);
               end
               expect_word(ST_OK, '0, 1'b1);
            end
         end
         RQ_DEL_HEAD: begin
            if (shadow_list.size() == 0) begin
               expect_word(ST_EMPTY, '0, 1'b1);
            end else begin
               head = shadow_list.pop_front();
               expect_word(ST_OK, head, 1'b1);
            end
         end
         RQ_DEL_VAL: begin
            foreach (shadow_list[i]) begin
               if (hit < 0 && shadow_list[i] == value) begin
                  hit = i;
               end
            end
            if (hit < 0) begin
               expect_word(ST_EMPTY, '0, 1'b1);
            end else begin
               shadow_list.delete(hit);
               expect_word(ST_OK, value, 1'b1);
            end
         end
         RQ_CLEAR: begin
            shadow_list.delete();
            expect_word(ST_OK, '0, 1'b1);
         end
         RQ_DUMP: begin
            if (shadow_list.size() == 0) begin
               expect_word(ST_EMPTY, '0, 1'b1);
            end else begin
               foreach (shadow_list[i]) begin
                  expect_word(ST_OK, shadow_list[i], i == shadow_list.size() - 1);
               end
            end
         end
         default: begin
            expect_word(ST_OK, '0, 1'b1);
         end
      endcase
   endfunction

   // request driver
   always @(negedge clock) begin : drive
      list_req_type nxt;
      if (!reset && !(req_valid && req_accepted != req_issued)) begin
         if (req_gap != 0) begin
            req_valid <= 1'b0;
            req_gap <= req_gap - 1;
         end else if (req_backlog.size() != 0) begin
            nxt = req_backlog.pop_front();
            req_valid <= 1'b1;
            req_type <= nxt.kind;
            req_item_value <= nxt.value;
            req_issued <= req_issued + 1;
            if ($urandom_range(0, 11) == 0) begin
               req_burst <= !req_burst;
            end
            req_gap <= req_burst ? 0 : $urandom_range(0, 14);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // response receiver, with one long hold-off
   always @(negedge clock) begin : receive
      int unsigned pause;
      if (!reset) begin
         if (rsp_ready && rsp_words != rsp_seen) begin
            rsp_seen <= rsp_words;
            if ($urandom_range(0, 11) == 0) begin
               rsp_burst <= !rsp_burst;
            end
            if (!hold_done && rsp_words >= HOLD_AT) begin
               hold_done <= 1'b1;
               rsp_ready <= 1'b0;
               rsp_wait <= HOLD_CYCLES;
            end else begin
               pause = rsp_burst ? 0 : $urandom_range(0, 14);
               if (pause != 0) begin
                  rsp_ready <= 1'b0;
                  rsp_wait <= pause - 1;
               end
            end
         end else if (!rsp_ready) begin
            if (rsp_wait == 0) begin
               rsp_ready <= 1'b1;
            end else begin
               rsp_wait <= rsp_wait - 1;
            end
         end
      end
   end

   // monitor, predictor and watchdog
   always @(posedge clock) begin : observe
      list_word_type due;
      if (!reset) begin
         if (req_valid && req_ready) begin
            list_apply(req_type, req_item_value);
            req_accepted <= req_accepted + 1;
         end
         if (rsp_valid && rsp_ready) begin
            rsp_words <= rsp_words + 1;
            if (words_due.size() == 0) begin
               $display("%0t: word with none due: expected none, actual status %0d value %0d",
                        $time, rsp_status, rsp_out_value);
               bad_words = bad_words + 1;
            end else begin
               due = words_due.pop_front();
               if (rsp_status !== due.status) begin
                  $display("%0t: status expected %0d actual %0d", $time, due.status, rsp_status);
                  bad_words = bad_words + 1;
               end
               if (rsp_out_value !== due.value) begin
                  $display("%0t: out_value expected %0d actual %0d", $time,
                           $signed(due.value), rsp_out_value);
                  bad_words = bad_words + 1;
               end
               if (rsp_last !== due.last) begin
                  $display("%0t: last expected %0d actual %0d", $time, due.last, rsp_last);
                  bad_words = bad_words + 1;
               end
               if (rsp_list_count !== due.count) begin
                  $display("%0t: list_count expected %0d actual %0d", $time,
                           due.count, rsp_list_count);
                  bad_words = bad_words + 1;
               end
            end
         end
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            stall_cycles <= 0;
         end else if (stall_cycles >= STALL_LIMIT) begin
            $display("%0t: no word moved for %0d cycles", $time, stall_cycles);
            $display("** bounded_linked_list_manager_core: FAILED **");
            $finish;
         end else begin
            stall_cycles <= stall_cycles + 1;
         end
      end
   end

   initial begin
      // empty list cases
      add_req(RQ_DUMP, 32'h0);
      add_req(RQ_DEL_HEAD, 32'h0);
      add_req(RQ_DEL_VAL, 32'h5);
      // extremes, duplicates, hits at head, tail and middle, a miss
      add_req(RQ_INS_HEAD, 32'h7fff_ffff);
      add_req(RQ_INS_HEAD, 32'h8000_0000);
      add_req(RQ_INS_TAIL, 32'h0);
      add_req(RQ_INS_TAIL, 32'hffff_ffff);
      add_req(RQ_INS_HEAD, 32'h0);
      add_req(RQ_DUMP, 32'hffff_ffff);
      add_req(RQ_DEL_VAL, 32'h0);
      add_req(RQ_DEL_VAL, 32'hffff_ffff);
      add_req(RQ_DEL_VAL, 32'd123);
      add_req(RQ_INS_TAIL, 32'd7);
      add_req(RQ_DEL_VAL, 32'h0);
      add_req(RQ_DUMP, 32'h0);
      add_req(RQ_DEL_HEAD, 32'h0);
      add_req(RQ_SPARE_A, 32'h5a5a_5a5a);
      add_req(RQ_SPARE_B, 32'ha5a5_a5a5);
      add_req(RQ_CLEAR, 32'h0);
      add_req(RQ_DUMP, 32'h0);
      add_req(RQ_DEL_HEAD, 32'h0);
      add_req(RQ_INS_TAIL, 32'h5a5a_5a5a);
      add_req(RQ_INS_HEAD, 32'ha5a5_a5a5);
      add_req(RQ_DUMP, 32'h0);
      add_req(RQ_CLEAR, 32'h0);

      repeat (4) add_mixed();

      // fill the pool past capacity, then work on a full list
      add_req(RQ_CLEAR, 32'h0);
      repeat (66) add_req($urandom_range(0, 1) ? RQ_INS_HEAD : RQ_INS_TAIL, pick_value());
      add_req(RQ_DUMP, 32'h0);
      repeat (3) add_req(RQ_DEL_VAL, pick_value());
      repeat (4) add_req(RQ_INS_TAIL, pick_value());
      add_req(RQ_DUMP, 32'h0);

      repeat (4) add_mixed();
      add_req(RQ_DUMP, 32'h0);
      items_total = req_backlog.size();

      repeat (5) @(negedge clock);
      reset <= 1'b0;

      while (req_accepted != items_total || words_due.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (bad_words == 0) begin
         $display("** bounded_linked_list_manager_core: PASSED **");
      end else begin
         $display("** bounded_linked_list_manager_core: FAILED **");
      end
      $finish;
   end

endmodule

`default_nettype wire

@@ bounded_linked_list_manager_core.f @@
hw/rtl/bllm_pkg.sv
hw/rtl/bllm_ctrl.sv
hw/rtl/bllm_datapath.sv
hw/rtl/bounded_linked_list_manager_core.sv
sim/tb.sv
